[sv/record_row_decoder_unit_defines.svh]
// Assertion macros used by the decoder controller.
// They expect a clock named clk and a synchronous reset named rst in scope.
`ifndef RECORD_ROW_DECODER_UNIT_DEFINES_SVH
`define RECORD_ROW_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/rrd_pkg.sv]
package rrd_pkg;

  localparam int MAX_COLUMNS = 32;
  localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
  localparam int NB_IDX_W    = $clog2(MAX_COLUMNS);
  localparam int BM_BYTES    = (MAX_COLUMNS + 7) / 8;
  localparam int BM_IDX_W    = $clog2(BM_BYTES);
  localparam int BM_CNT_W    = $clog2(BM_BYTES + 1);
  localparam int TEXT_MAP_W  = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int TDATA_OUT_W = 112;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_IS_TEXT = 1'b1;

  localparam logic [2:0] INT_LAST_BYTE = 3'd7;
  localparam logic [2:0] LEN_LAST_BYTE = 3'd3;

  typedef enum logic [2:0] {
    KIND_NULL   = 3'd0,
    KIND_INT    = 3'd1,
    KIND_HDR    = 3'd2,
    KIND_TBYTE  = 3'd3,
    KIND_STATUS = 3'd4
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load_bitmap;
    logic  inc_idx;
    logic  load_asm;
    logic  inc_fbc;
    logic  field_clear;
    logic  load_len;
    logic  dec_left;
    logic  col_zero;
    logic  col_inc;
    logic  rec_clear;
    logic  emit;
    kind_t kind;
    logic  last;
    logic  status;
  } rrd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic need_zero;
    logic bm_last;
    logic int_last;
    logic len_last;
    logic len_zero;
    logic left_one;
    logic cur_in_range;
    logic cur_null;
    logic cur_text;
    logic next_null;
  } rrd_sts_t;

endpackage

[sv/rrd_datapath.sv]
module rrd_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [7:0]                       in_byte,
  input  rrd_pkg::rrd_cmd_t                cmd,
  output rrd_pkg::rrd_sts_t                sts,
  input  logic                             m_tready,
  output logic                             m_tvalid,
  output logic [rrd_pkg::TDATA_OUT_W-1:0]  m_tdata,
  output logic [2:0]                       m_tuser,
  output logic                             m_tlast
);

  logic [rrd_pkg::COL_W-1:0]       column_count;
  logic [rrd_pkg::TEXT_MAP_W-1:0]  column_is_text;
  logic [rrd_pkg::COL_W-1:0]       cur_col;
  logic [rrd_pkg::MAX_COLUMNS-1:0] null_bits;
  logic [rrd_pkg::BM_IDX_W-1:0]    bm_idx;
  logic [2:0]                      fbc;
  logic [63:0]                     asm_reg;
  logic [31:0]                     text_left;

  logic                            out_valid;
  logic [4:0]                      out_col;
  rrd_pkg::kind_t                  out_kind;
  logic [63:0]                     out_int;
  logic [31:0]                     out_len;
  logic [7:0]                      out_tbyte;
  logic                            out_status;
  logic                            out_last;

  logic [rrd_pkg::COL_W-1:0]       cols;
  logic [rrd_pkg::BM_CNT_W-1:0]    need;
  logic [rrd_pkg::COL_W-1:0]       cur_p1;
  logic [63:0]                     int_value;
  logic [31:0]                     len_value;

  // Column counts above the storage limit are clamped.
  assign cols = (column_count > rrd_pkg::COL_W'(rrd_pkg::MAX_COLUMNS)) ?
                rrd_pkg::COL_W'(rrd_pkg::MAX_COLUMNS) : column_count;
  assign need = rrd_pkg::BM_CNT_W'((cols + rrd_pkg::COL_W'(7)) >> 3);
  assign cur_p1 = cur_col + rrd_pkg::COL_W'(1);
  assign int_value = {in_byte, asm_reg[55:0]};
  assign len_value = {in_byte, asm_reg[23:0]};

  always_comb begin
    sts.out_free     = !out_valid || m_tready;
    sts.need_zero    = (cols == '0);
    sts.bm_last      = (rrd_pkg::BM_CNT_W'(bm_idx) + rrd_pkg::BM_CNT_W'(1)) >= need;
    sts.int_last     = (fbc >= rrd_pkg::INT_LAST_BYTE);
    sts.len_last     = (fbc >= rrd_pkg::LEN_LAST_BYTE);
    sts.len_zero     = (len_value == '0);
    sts.left_one     = (text_left == 32'd1);
    sts.cur_in_range = (cur_col < cols);
    sts.cur_null     = null_bits[cur_col[rrd_pkg::NB_IDX_W-1:0]];
    sts.cur_text     = (cur_col < rrd_pkg::COL_W'(rrd_pkg::TEXT_MAP_W)) &&
                       column_is_text[cur_col[4:0]];
    sts.next_null    = (cur_p1 < cols) && null_bits[cur_p1[rrd_pkg::NB_IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= rrd_pkg::COL_W'(1);
      column_is_text <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrd_pkg::CFG_COLUMN_COUNT:   column_count   <= cfg_data[rrd_pkg::COL_W-1:0];
        rrd_pkg::CFG_COLUMN_IS_TEXT: column_is_text <= cfg_data[rrd_pkg::TEXT_MAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Parse state. A record clear wins over anything else issued in the same cycle.
  always_ff @(posedge clk) begin
    if (rst || cmd.rec_clear) begin
      cur_col   <= '0;
      null_bits <= '0;
      bm_idx    <= '0;
      fbc       <= '0;
      text_left <= '0;
    end else begin
      if (cmd.load_bitmap) begin
        null_bits[{bm_idx, 3'b000} +: 8] <= in_byte;
      end
      if (cmd.inc_idx) begin
        bm_idx <= bm_idx + rrd_pkg::BM_IDX_W'(1);
      end
      if (cmd.field_clear) begin
        fbc <= '0;
      end else if (cmd.inc_fbc) begin
        fbc <= fbc + 3'd1;
      end
      if (cmd.col_zero) begin
        cur_col <= '0;
      end else if (cmd.col_inc) begin
        cur_col <= cur_p1;
      end
      if (cmd.load_len) begin
        text_left <= len_value;
      end else if (cmd.dec_left) begin
        text_left <= text_left - 32'd1;
      end
    end
  end

  // Each byte slot is written once per field, so no clear is needed.
  always_ff @(posedge clk) begin
    if (cmd.load_asm) begin
      asm_reg[{fbc, 3'b000} +: 8] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Fields that do not belong to the issued kind are sent as zero.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind   <= cmd.kind;
      out_last   <= cmd.last;
      out_col    <= (cmd.kind == rrd_pkg::KIND_STATUS) ? 5'd0 : cur_col[4:0];
      out_int    <= (cmd.kind == rrd_pkg::KIND_INT) ? int_value : 64'd0;
      out_len    <= (cmd.kind == rrd_pkg::KIND_HDR) ? len_value : 32'd0;
      out_tbyte  <= (cmd.kind == rrd_pkg::KIND_TBYTE) ? in_byte : 8'd0;
      out_status <= (cmd.kind == rrd_pkg::KIND_STATUS) && cmd.status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_status, out_tbyte, out_len, out_int, out_col};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule

[sv/rrd_ctrl.sv]
`include "record_row_decoder_unit_defines.svh"

module rrd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  output logic              s_tready,
  input  rrd_pkg::rrd_sts_t sts,
  output rrd_pkg::rrd_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_BITMAP,
    ST_INT,
    ST_TLEN,
    ST_TBODY,
    ST_DONE,
    ST_ADVANCE,
    ST_STATUS
  } state_t;

  state_t state;
  state_t state_next;
  state_t phase_next;
  logic   eor_hold;
  logic   eor_hold_next;
  logic   trunc;
  logic   trunc_next;
  logic   parsing;
  logic   accept;
  logic   go_adv;

  assign parsing  = (state == ST_BITMAP) || (state == ST_INT) || (state == ST_TLEN) ||
                    (state == ST_TBODY) || (state == ST_DONE);
  assign s_tready = parsing && sts.out_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    phase_next    = state;
    eor_hold_next = eor_hold;
    trunc_next    = trunc;
    go_adv        = 1'b0;

    unique case (state)
      ST_BITMAP, ST_INT, ST_TLEN, ST_TBODY, ST_DONE: begin
        if (accept) begin
          unique case (state)
            ST_BITMAP: begin
              if (sts.need_zero) begin
                phase_next = ST_DONE;
              end else begin
                cmd.load_bitmap = 1'b1;
                if (sts.bm_last) begin
                  cmd.col_zero = 1'b1;
                  go_adv       = 1'b1;
                end else begin
                  cmd.inc_idx = 1'b1;
                end
              end
            end
            ST_INT: begin
              cmd.load_asm = 1'b1;
              if (sts.int_last) begin
                cmd.emit    = 1'b1;
                cmd.kind    = rrd_pkg::KIND_INT;
                cmd.col_inc = 1'b1;
                go_adv      = 1'b1;
              end else begin
                cmd.inc_fbc = 1'b1;
              end
            end
            ST_TLEN: begin
              cmd.load_asm = 1'b1;
              if (sts.len_last) begin
                cmd.emit     = 1'b1;
                cmd.kind     = rrd_pkg::KIND_HDR;
                cmd.load_len = 1'b1;
                if (sts.len_zero) begin
                  cmd.col_inc = 1'b1;
                  go_adv      = 1'b1;
                end else begin
                  phase_next = ST_TBODY;
                end
              end else begin
                cmd.inc_fbc = 1'b1;
              end
            end
            ST_TBODY: begin
              cmd.emit     = 1'b1;
              cmd.kind     = rrd_pkg::KIND_TBYTE;
              cmd.dec_left = 1'b1;
              if (sts.left_one) begin
                cmd.col_inc = 1'b1;
                go_adv      = 1'b1;
              end
            end
            default: ;
          endcase

          // A null run after a finished field still follows this result.
          cmd.last = !s_tlast && !(go_adv && sts.next_null);

          if (go_adv) begin
            state_next    = ST_ADVANCE;
            eor_hold_next = s_tlast;
          end else if (s_tlast) begin
            if (cmd.emit) begin
              state_next = ST_STATUS;
              trunc_next = (phase_next != ST_DONE);
            end else begin
              cmd.emit      = 1'b1;
              cmd.kind      = rrd_pkg::KIND_STATUS;
              cmd.status    = (phase_next != ST_DONE);
              cmd.last      = 1'b1;
              cmd.rec_clear = 1'b1;
              state_next    = ST_BITMAP;
            end
          end else begin
            state_next = phase_next;
          end
        end
      end
      ST_ADVANCE: begin
        if (sts.out_free) begin
          if (sts.cur_in_range && sts.cur_null) begin
            cmd.emit    = 1'b1;
            cmd.kind    = rrd_pkg::KIND_NULL;
            cmd.last    = !eor_hold && !sts.next_null;
            cmd.col_inc = 1'b1;
          end else begin
            if (!sts.cur_in_range) begin
              phase_next = ST_DONE;
            end else if (sts.cur_text) begin
              phase_next = ST_TLEN;
            end else begin
              phase_next = ST_INT;
            end
            cmd.field_clear = 1'b1;
            if (eor_hold) begin
              cmd.emit      = 1'b1;
              cmd.kind      = rrd_pkg::KIND_STATUS;
              cmd.status    = (phase_next != ST_DONE);
              cmd.last      = 1'b1;
              cmd.rec_clear = 1'b1;
              state_next    = ST_BITMAP;
            end else begin
              state_next = phase_next;
            end
          end
        end
      end
      ST_STATUS: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = rrd_pkg::KIND_STATUS;
          cmd.status    = trunc;
          cmd.last      = 1'b1;
          cmd.rec_clear = 1'b1;
          state_next    = ST_BITMAP;
        end
      end
      default: state_next = ST_BITMAP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_BITMAP;
      eor_hold <= 1'b0;
      trunc    <= 1'b0;
    end else begin
      state    <= state_next;
      eor_hold <= eor_hold_next;
      trunc    <= trunc_next;
    end
  end

  `RRD_ASSERT_NOW(a_no_input_in_walk, (state == ST_ADVANCE) || (state == ST_STATUS), !s_tready, "input taken while walking columns")
  `RRD_ASSERT_NOW(a_emit_needs_room, cmd.emit, sts.out_free, "result issued into a full output register")
  `RRD_ASSERT_NOW(a_status_ends_rec, cmd.emit && (cmd.kind == rrd_pkg::KIND_STATUS), cmd.rec_clear && cmd.last, "status without record end")
  `RRD_ASSERT_NEXT(a_clear_to_bitmap, cmd.rec_clear, state == ST_BITMAP, "record end did not return to bitmap")

endmodule

[sv/record_row_decoder_unit.sv]
// Channel  Dir  Fields (low bit first)
// s_*      in   tdata: data_byte[7:0]; tlast: end_of_record
// m_*      out  tdata: column_index, int_value, text_length, text_byte, record_status, pad;
//               tuser: item_kind; tlast: last_of_run
// cfg_*    in   cfg_index 0 column_count, 1 column_is_text; write on cfg_we
//
// Field bytes (bitmap, integer, text length, text body) are taken one per cycle while
// s_tready is high. After each completed field the controller walks the columns and
// issues one null result per null column that follows it, since every result passes
// through the single output register. A status after an emitting byte waits in its own state.
// Reset is synchronous; it restores column_count 1 and column_is_text 0.
// A stall on m_tready holds the output register and blocks s_tready.
module record_row_decoder_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,  // data_byte
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // column_index[4:0], int_value[68:5], text_length[100:69],
  // text_byte[108:101], record_status[109], zero pad[111:110]
  output logic [rrd_pkg::TDATA_OUT_W-1:0]  m_tdata,
  output logic [2:0]                       m_tuser,  // item_kind
  output logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic [rrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rrd_pkg::rrd_cmd_t cmd;
  rrd_pkg::rrd_sts_t sts;

  rrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
